// ===== hw/rtl/hhr_pkg.sv =====
// ----------------------------------------------------------------------------
// Havel-Hakimi realizer package
// Shared widths, item types and the job handed from loader to engine.
// ----------------------------------------------------------------------------
`default_nettype none

package hhr_pkg;

  localparam int MaxVert  = 8;
  localparam int DegW     = 8;
  localparam int VIdxW    = $clog2(MaxVert);
  localparam int CntW     = $clog2(MaxVert + 1);
  localparam int EdgeCap  = (MaxVert * (MaxVert - 1)) / 2;
  localparam int EdgeCntW = $clog2(EdgeCap + 1);
  localparam int EdgeAW   = $clog2(EdgeCap);

  localparam logic KindEdge    = 1'b0;
  localparam logic KindVerdict = 1'b1;

  typedef struct packed {
    logic signed [7:0] degree;
    logic              last;
  } in_item_t;

  typedef struct packed {
    logic       kind;
    logic [2:0] from_vertex;
    logic [2:0] to_vertex;
    logic       is_graphic;
    logic       final_item;
  } out_item_t;

  typedef struct packed {
    logic [MaxVert-1:0][DegW-1:0] degs;
    logic [CntW-1:0]              n;
    logic                         fail;
  } job_t;

endpackage

`default_nettype wire

// ===== hw/rtl/hhr_front.sv =====
// ----------------------------------------------------------------------------
// Havel-Hakimi realizer front end
// Loads degrees, tracks parity and overflow, and queues one finished job.
// ----------------------------------------------------------------------------
`default_nettype none

module hhr_front import hhr_pkg::*; (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     push,
  output logic          full,
  input  wire in_item_t data_i,
  output logic          job_valid_o,
  output job_t          job_o,
  input  wire logic     job_pop_i
);

  logic [MaxVert-1:0][DegW-1:0] degs_q;
  logic [CntW-1:0]              cnt_q;
  logic                         par_q;
  logic                         many_q;
  job_t                         job_q;
  logic                         job_valid_q;

  logic                         accept;
  logic                         room;
  logic [MaxVert-1:0][DegW-1:0] degs_d;
  logic                         par_d;
  logic                         many_d;
  logic [CntW-1:0]              cnt_d;

  assign full        = job_valid_q;
  assign accept      = push && !job_valid_q;
  assign room        = (cnt_q < CntW'(MaxVert));
  assign job_valid_o = job_valid_q;
  assign job_o       = job_q;

  always_comb begin
    degs_d = degs_q;
    par_d  = par_q;
    many_d = many_q;
    cnt_d  = cnt_q;
    if (room) begin
      degs_d[cnt_q[VIdxW-1:0]] = data_i.degree;
      par_d                    = par_q ^ data_i.degree[0];
      cnt_d                    = cnt_q + CntW'(1);
    end else begin
      many_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      par_q       <= 1'b0;
      many_q      <= 1'b0;
      job_valid_q <= 1'b0;
    end else begin
      if (job_pop_i) job_valid_q <= 1'b0;
      if (accept) begin
        if (data_i.last) begin
          job_valid_q <= 1'b1;
          cnt_q       <= '0;
          par_q       <= 1'b0;
          many_q      <= 1'b0;
        end else begin
          cnt_q  <= cnt_d;
          par_q  <= par_d;
          many_q <= many_d;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    degs_q <= accept ? degs_d : degs_q;
    if (accept && data_i.last) begin
      job_q.degs <= degs_d;
      job_q.n    <= cnt_d;
      job_q.fail <= many_d | par_d;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/hhr_back.sv =====
// ----------------------------------------------------------------------------
// Havel-Hakimi realizer engine
// Sorts, runs the rounds, buffers edges and drives the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module hhr_back import hhr_pkg::*; (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  job_valid_i,
  input  wire job_t  job_i,
  output logic       job_pop_o,
  output logic       empty,
  input  wire logic  pop,
  output out_item_t  data_o
);

  typedef enum logic [6:0] {
    ST_IDLE    = 7'b0000001,
    ST_SORT    = 7'b0000010,
    ST_CHECK   = 7'b0000100,
    ST_ROUND   = 7'b0001000,
    ST_EMIT_RD = 7'b0010000,
    ST_EMIT_WR = 7'b0100000,
    ST_VERDICT = 7'b1000000
  } state_e;

  state_e                    state_q;
  logic signed [DegW-1:0]    deg_q [MaxVert];
  logic signed [DegW-1:0]    deg_d [MaxVert];
  logic [VIdxW-1:0]          lab_q [MaxVert];
  logic [VIdxW-1:0]          lab_d [MaxVert];
  logic [CntW-1:0]           n_q;
  logic [VIdxW-1:0]          phase_q;
  logic [CntW-1:0]           idx_q;
  logic                      first_q;
  logic                      ok_q;
  logic [EdgeCntW-1:0]       ecnt_q;
  logic [EdgeCntW-1:0]       ptr_q;
  logic [2*VIdxW-1:0]        mem [EdgeCap];
  logic [2*VIdxW-1:0]        rd_q;
  out_item_t                 out_q;
  logic                      out_valid_q;

  logic                      out_free;
  logic                      load_edge;
  logic                      load_verdict;
  logic signed [DegW-1:0]    deg_top;
  logic signed [DegW-1:0]    deg_tail;
  logic signed [DegW-1:0]    n_max;
  logic signed [DegW-1:0]    idx_s;
  logic                      step_go;
  logic                      edge_room;
  logic                      all_zero;
  logic [CntW-1:0]           n_m1;

  assign out_free     = !out_valid_q || pop;
  assign load_edge    = (state_q == ST_EMIT_WR) && out_free;
  assign load_verdict = (state_q == ST_VERDICT) && out_free;
  assign job_pop_o    = (state_q == ST_IDLE) && job_valid_i;
  assign empty        = !out_valid_q;
  assign data_o       = out_q;

  assign n_m1      = n_q - CntW'(1);
  assign deg_top   = deg_q[0];
  assign deg_tail  = deg_q[n_m1[VIdxW-1:0]];
  assign n_max     = DegW'(n_m1);
  assign idx_s     = DegW'(idx_q);
  assign step_go   = (idx_s <= deg_top) && (idx_q < n_q);
  assign edge_room = (ecnt_q < EdgeCntW'(EdgeCap));

  always_comb begin
    all_zero = 1'b1;
    for (int k = 0; k < MaxVert; k++) begin
      if ((CntW'(k) < n_q) && (deg_q[k] != '0)) all_zero = 1'b0;
    end
  end

  // odd-even transposition pass
  always_comb begin
    for (int k = 0; k < MaxVert; k++) begin
      deg_d[k] = deg_q[k];
      lab_d[k] = lab_q[k];
    end
    for (int j = 0; j < MaxVert - 1; j++) begin
      if ((j % 2 == int'(phase_q[0])) && (CntW'(j + 1) < n_q)) begin
        if ((deg_q[j+1] > deg_q[j]) ||
            ((deg_q[j+1] == deg_q[j]) && (lab_q[j+1] < lab_q[j]))) begin
          deg_d[j]   = deg_q[j+1];
          deg_d[j+1] = deg_q[j];
          lab_d[j]   = lab_q[j+1];
          lab_d[j+1] = lab_q[j];
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
      ecnt_q      <= '0;
      ptr_q       <= '0;
      phase_q     <= '0;
      idx_q       <= '0;
      first_q     <= 1'b0;
      ok_q        <= 1'b0;
    end else begin
      if (load_edge || load_verdict) out_valid_q <= 1'b1;
      else if (pop)                  out_valid_q <= 1'b0;
      unique case (state_q)
        ST_IDLE: begin
          if (job_valid_i) begin
            ecnt_q  <= '0;
            ptr_q   <= '0;
            phase_q <= '0;
            first_q <= 1'b1;
            ok_q    <= 1'b0;
            state_q <= job_i.fail ? ST_VERDICT : ST_SORT;
          end
        end
        ST_SORT: begin
          phase_q <= phase_q + VIdxW'(1);
          if (phase_q == VIdxW'(MaxVert - 1)) state_q <= ST_CHECK;
        end
        ST_CHECK: begin
          idx_q   <= CntW'(1);
          first_q <= 1'b0;
          if (first_q) begin
            if ((deg_top > n_max) || (deg_tail < 0)) state_q <= ST_VERDICT;
            else                                     state_q <= ST_ROUND;
          end else if ((deg_top == '0) || (deg_tail < 0)) begin
            ok_q    <= all_zero;
            state_q <= !all_zero ? ST_VERDICT :
                       (ecnt_q == '0) ? ST_VERDICT : ST_EMIT_RD;
          end else begin
            state_q <= ST_ROUND;
          end
        end
        ST_ROUND: begin
          if (step_go) begin
            idx_q <= idx_q + CntW'(1);
            if (edge_room) ecnt_q <= ecnt_q + EdgeCntW'(1);
          end else begin
            phase_q <= '0;
            state_q <= ST_SORT;
          end
        end
        ST_EMIT_RD: state_q <= ST_EMIT_WR;
        ST_EMIT_WR: begin
          if (out_free) begin
            ptr_q   <= ptr_q + EdgeCntW'(1);
            state_q <= (ptr_q + EdgeCntW'(1) == ecnt_q) ? ST_VERDICT : ST_EMIT_RD;
          end
        end
        ST_VERDICT: begin
          if (out_free) state_q <= ST_IDLE;
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (job_pop_o) begin
      for (int k = 0; k < MaxVert; k++) begin
        deg_q[k] <= job_i.degs[k];
        lab_q[k] <= VIdxW'(k);
      end
      n_q <= job_i.n;
    end else if (state_q == ST_SORT) begin
      for (int k = 0; k < MaxVert; k++) begin
        deg_q[k] <= deg_d[k];
        lab_q[k] <= lab_d[k];
      end
    end else if (state_q == ST_ROUND) begin
      if (step_go) begin
        deg_q[idx_q[VIdxW-1:0]] <= deg_q[idx_q[VIdxW-1:0]] - DegW'(1);
        if (edge_room) mem[ecnt_q[EdgeAW-1:0]] <= {lab_q[0], lab_q[idx_q[VIdxW-1:0]]};
      end else begin
        deg_q[0] <= '0;
      end
    end
    if (state_q == ST_EMIT_RD) rd_q <= mem[ptr_q[EdgeAW-1:0]];
    if (load_edge) begin
      out_q.kind        <= KindEdge;
      out_q.from_vertex <= 3'(rd_q[2*VIdxW-1:VIdxW]);
      out_q.to_vertex   <= 3'(rd_q[VIdxW-1:0]);
      out_q.is_graphic  <= 1'b0;
      out_q.final_item  <= 1'b0;
    end else if (load_verdict) begin
      out_q.kind        <= KindVerdict;
      out_q.from_vertex <= '0;
      out_q.to_vertex   <= '0;
      out_q.is_graphic  <= ok_q;
      out_q.final_item  <= 1'b1;
    end
  end

  a_ecnt_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ecnt_q <= EdgeCntW'(EdgeCap))
    else $error("edge count past capacity");

  a_emit_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_EMIT_RD || state_q == ST_EMIT_WR) |-> ok_q)
    else $error("edges emitted for a failed run");

  a_verdict_final: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_verdict |=> (out_valid_q && out_q.final_item && out_q.kind == KindVerdict))
    else $error("verdict not marked final");

  a_job_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    job_pop_o |=> (state_q != ST_IDLE))
    else $error("job taken without starting");

endmodule

`default_nettype wire

// ===== hw/rtl/degree_sequence_graph_realizer.sv =====
// ----------------------------------------------------------------------------
// Degree sequence graph realizer
// Havel-Hakimi realization of a loaded degree sequence, edges then verdict.
// ----------------------------------------------------------------------------
//  channel   handshake          payload
//  input     push / full        data_i  (degree, last)
//  result    empty / pop        data_o  (kind, from/to vertex, is_graphic, final)
//
//  Loading takes one degree per cycle; the input stalls only while a finished
//  sequence waits for the engine. The engine picks up a sequence, sorts it
//  (8 sort passes) and checks it; each round records one edge per decremented
//  neighbour, clears the top degree, then sorts and checks again. Emitting
//  loads each buffered edge, then the verdict, and waits while pop is low.
//  Reset clears all control state; no clearing pass is needed.
// ----------------------------------------------------------------------------
`default_nettype none

module degree_sequence_graph_realizer import hhr_pkg::*; (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     push,
  output logic          full,
  input  wire in_item_t data_i,
  output logic          empty,
  input  wire logic     pop,
  output out_item_t     data_o
);

  logic job_valid;
  job_t job;
  logic job_pop;

  hhr_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push        (push),
    .full        (full),
    .data_i      (data_i),
    .job_valid_o (job_valid),
    .job_o       (job),
    .job_pop_i   (job_pop)
  );

  hhr_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_valid_i (job_valid),
    .job_i       (job),
    .job_pop_o   (job_pop),
    .empty       (empty),
    .pop         (pop),
    .data_o      (data_o)
  );

endmodule

`default_nettype wire

// ===== tb/degree_sequence_graph_realizer_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Degree sequence graph realizer testbench
// Loads degree sequences through the request queue interface and checks
// every edge and verdict against a Havel-Hakimi predictor in this file.
// A table of directed sequences comes first, then random sequences, under
// three idle profiles on the push and pop sides.
// ----------------------------------------------------------------------------
`default_nettype none

module degree_sequence_graph_realizer_tb;
  import hhr_pkg::*;

  localparam int WatchdogLimit = 20000;
  localparam int DrainCycles   = 400;
  localparam int NumDirected   = 21;

  logic      clk_i;
  logic      rst_ni;
  logic      push;
  logic      full;
  in_item_t  data_i;
  logic      empty;
  logic      pop;
  out_item_t data_o;

  degree_sequence_graph_realizer dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .push  (push),
    .full  (full),
    .data_i(data_i),
    .empty (empty),
    .pop   (pop),
    .data_o(data_o)
  );

  // Predictor state.
  int        seq_deg[MaxVert];
  int        seq_lbl[MaxVert];
  int        seq_n;
  bit        seq_odd;
  bit        seq_over;
  int        edge_from[EdgeCap];
  int        edge_to[EdgeCap];
  int        edge_num;
  out_item_t expected_items[$];

  int  errors;
  int  typed_errors;
  int  idle_push_pct;
  int  idle_pop_pct;
  int  stall_count;

  // Directed table: degrees, last flags, and a typed-in verdict (-1 = predicted).
  logic signed [7:0] dir_deg[NumDirected];
  bit                dir_last[NumDirected];
  int                dir_verdict[NumDirected];

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  function automatic void sort_vertices();
    int d;
    int lb;
    int j;
    for (int i = 1; i < seq_n; i++) begin
      d  = seq_deg[i];
      lb = seq_lbl[i];
      j  = i;
      while (j > 0 && (seq_deg[j-1] < d || (seq_deg[j-1] == d && seq_lbl[j-1] > lb))) begin
        seq_deg[j] = seq_deg[j-1];
        seq_lbl[j] = seq_lbl[j-1];
        j--;
      end
      seq_deg[j] = d;
      seq_lbl[j] = lb;
    end
  endfunction

  function automatic bit realize_sequence();
    int d;
    if (seq_over || seq_n == 0 || seq_odd) return 1'b0;
    sort_vertices();
    if (seq_deg[0] > seq_n - 1 || seq_deg[seq_n-1] < 0) return 1'b0;
    for (int r = 0; r <= EdgeCap; r++) begin
      d = seq_deg[0];
      for (int i = 1; i <= d && i < seq_n; i++) begin
        seq_deg[i] -= 1;
        if (edge_num < EdgeCap) begin
          edge_from[edge_num] = seq_lbl[0];
          edge_to[edge_num]   = seq_lbl[i];
          edge_num++;
        end
      end
      seq_deg[0] = 0;
      sort_vertices();
      if (seq_deg[0] == 0 || seq_deg[seq_n-1] < 0) break;
    end
    for (int i = 0; i < seq_n; i++)
      if (seq_deg[i] != 0) return 1'b0;
    return 1'b1;
  endfunction

  // Returns the verdict when the request closes a sequence, else -1.
  function automatic int predict_request(in_item_t req);
    bit        ok;
    out_item_t item;
    if (seq_n < MaxVert) begin
      seq_deg[seq_n] = int'(req.degree);
      seq_lbl[seq_n] = seq_n;
      seq_n++;
      seq_odd ^= req.degree[0];
    end else begin
      seq_over = 1'b1;
    end
    if (!req.last) return -1;
    edge_num = 0;
    ok = realize_sequence();
    if (ok) begin
      for (int e = 0; e < edge_num; e++) begin
        item = '{KindEdge, 3'(edge_from[e]), 3'(edge_to[e]), 1'b0, 1'b0};
        expected_items = {expected_items, item};
      end
    end
    item = '{KindVerdict, 3'd0, 3'd0, ok, 1'b1};
    expected_items = {expected_items, item};
    seq_n    = 0;
    seq_odd  = 1'b0;
    seq_over = 1'b0;
    return int'(ok);
  endfunction

  task automatic send_request(logic signed [7:0] deg, bit last, int verdict);
    in_item_t req;
    int       got;
    while ($urandom_range(99) < idle_push_pct) begin
      push <= 1'b0;
      @(posedge clk_i);
    end
    req.degree = deg;
    req.last   = last;
    push   <= 1'b1;
    data_i <= req;
    @(posedge clk_i);
    while (full) @(posedge clk_i);
    got = predict_request(req);
    if (verdict >= 0 && got != verdict) begin
      $error("is_graphic typed: expected %0d actual %0d", verdict, got);
      typed_errors++;
    end
  endtask

  task automatic send_random_sequence();
    int n;
    int kind;
    logic signed [7:0] d;
    kind = $urandom_range(9);
    n    = (kind == 0) ? $urandom_range(12, 9) : $urandom_range(MaxVert, 1);
    for (int i = 0; i < n; i++) begin
      if (kind <= 6 && kind > 0) d = 8'($urandom_range(n - 1));
      else if (kind == 7) d = 8'($urandom_range(n + 1));
      else d = 8'($urandom());
      send_request(d, i == n - 1, -1);
    end
  endtask

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      pop         <= 1'b0;
      stall_count <= 0;
    end else begin
      pop <= ($urandom_range(99) >= idle_pop_pct);
      if (pop && !empty) begin
        if (expected_items.size() == 0) begin
          $error("unexpected result kind=%0d", data_o.kind);
          errors++;
        end else begin
          if (data_o.kind !== expected_items[0].kind) begin
            $error("kind: expected %0d actual %0d", expected_items[0].kind, data_o.kind);
            errors++;
          end
          if (data_o.from_vertex !== expected_items[0].from_vertex) begin
            $error("from_vertex: expected %0d actual %0d",
                   expected_items[0].from_vertex, data_o.from_vertex);
            errors++;
          end
          if (data_o.to_vertex !== expected_items[0].to_vertex) begin
            $error("to_vertex: expected %0d actual %0d",
                   expected_items[0].to_vertex, data_o.to_vertex);
            errors++;
          end
          if (data_o.is_graphic !== expected_items[0].is_graphic) begin
            $error("is_graphic: expected %0d actual %0d",
                   expected_items[0].is_graphic, data_o.is_graphic);
            errors++;
          end
          if (data_o.final_item !== expected_items[0].final_item) begin
            $error("final_item: expected %0d actual %0d",
                   expected_items[0].final_item, data_o.final_item);
            errors++;
          end
          void'(expected_items.pop_front());
        end
      end
      if ((push && !full) || (pop && !empty)) stall_count <= 0;
      else stall_count <= stall_count + 1;
    end
  end

  always @(posedge clk_i) begin
    if (stall_count >= WatchdogLimit) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  initial begin
    int row;
    int k;
    typed_errors = 0;
    seq_n = 0;
    seq_odd = 1'b0;
    seq_over = 1'b0;
    edge_num = 0;
    idle_push_pct = 22;
    idle_pop_pct = 54;
    push = 1'b0;
    data_i = '0;
    rst_ni = 1'b0;
    // Rows: single zero; triangle; odd sum; negative; too-large degree; odd sum;
    // extremes; too many vertices. A complete graph on eight vertices follows.
    dir_deg  = '{8'sd0, 8'sd2, 8'sd2, 8'sd2, 8'sd1, 8'sd0, -8'sd1, 8'sd1, 8'sd3,
                 8'sd1, 8'sd127, 8'sh80, 8'sd0, 8'sd0, 8'sd0, 8'sd0, 8'sd0,
                 8'sd0, 8'sd0, 8'sd0, 8'sd0};
    dir_last = '{1'b1, 1'b0, 1'b0, 1'b1, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b1, 1'b0,
                 1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1};
    dir_verdict = '{1, -1, -1, 1, 0, -1, 0, -1, 0, 0, -1, 0,
                    -1, -1, -1, -1, -1, -1, -1, -1, 0};
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    for (row = 0; row < NumDirected; row++)
      send_request(dir_deg[row], dir_last[row], dir_verdict[row]);
    for (row = 0; row < MaxVert; row++)
      send_request(8'sd7, row == MaxVert - 1, (row == MaxVert - 1) ? 1 : -1);
    for (int phase = 0; phase < 3; phase++) begin
      idle_push_pct = (phase == 0) ? 22 : (phase == 1) ? 54 : 0;
      idle_pop_pct  = (phase == 0) ? 54 : (phase == 1) ? 22 : 0;
      k = 0;
      while (k < 19) begin
        send_random_sequence();
        k++;
      end
    end
    push <= 1'b0;
    while (expected_items.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (errors == 0 && typed_errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ===== sim.f =====
hw/rtl/hhr_pkg.sv
hw/rtl/hhr_front.sv
hw/rtl/hhr_back.sv
hw/rtl/degree_sequence_graph_realizer.sv
tb/degree_sequence_graph_realizer_tb.sv
